FILE: rtl/scalar_kalman_angle_fusion_unit_assert.svh
// Assertion macros used by the fusion unit's top-level RTL
`ifndef SCALAR_KALMAN_ANGLE_FUSION_UNIT_ASSERT_SVH
`define SCALAR_KALMAN_ANGLE_FUSION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SKAF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SKAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/skaf_pkg.sv
// Types, constants, microcode table and helpers of the angle fusion unit
package skaf_pkg;

  // Field and format constants
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int IO_FRAC          = 8;
  localparam int GAIN_W           = 16;
  localparam int GAIN_FRAC        = 8;
  localparam int PERIOD_W         = 16;
  localparam int PERIOD_FRAC      = 16;
  localparam int PNOISE_W         = 24;
  localparam int RNOISE_W         = 32;
  localparam int K_BITS           = 30;
  localparam int ACC_W            = 32;
  localparam int COV_W            = 32;
  localparam int GP_W             = GAIN_W + PERIOD_W;
  localparam int MUL_W            = ACC_W + 1;
  localparam int PROD_W           = 2 * MUL_W;
  localparam int WIDE             = PROD_W + 2;
  localparam int CNT_W            = $clog2(K_BITS + 1);
  localparam int STEP_W           = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd3;

  // Reset values
  localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST    = 16'd1152;
  localparam logic [PERIOD_W-1:0] PERIOD_RST       = 16'd1049;
  localparam logic [PNOISE_W-1:0] PNOISE_RST       = 24'd3277;
  localparam logic [RNOISE_W-1:0] RNOISE_RST       = 32'd65536000;
  localparam logic [COV_W-1:0]    COV_RST          = 32'd19660800;

  // Saturation bounds of the estimate, held in the wide datapath format
  localparam logic signed [WIDE-1:0] ACC_MAX =
    {{(WIDE - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
  localparam logic signed [WIDE-1:0] ACC_MIN = ~ACC_MAX;

  // Microcode step addresses
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_RATE     = 4'd1;
  localparam step_t STEP_PRED_RND = 4'd2;
  localparam step_t STEP_PRED_ADD = 4'd3;
  localparam step_t STEP_DIV      = 4'd4;
  localparam step_t STEP_GAIN     = 4'd5;
  localparam step_t STEP_CORR_MUL = 4'd6;
  localparam step_t STEP_CORR_RND = 4'd7;
  localparam step_t STEP_CORR_ADD = 4'd8;
  localparam step_t STEP_COV_RND  = 4'd9;
  localparam step_t STEP_OUT      = 4'd10;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GAIN_PERIOD,
    MUL_RATE,
    MUL_DIFF_K,
    MUL_COV_KC
  } mul_src_t;

  typedef enum logic [1:0] {
    RND_NONE,
    RND_PRED,
    RND_GAIN
  } rnd_src_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_LOOP,
    COND_OUT_BUSY
  } cond_t;

  // Datapath controls of one step
  typedef struct packed {
    logic     in_ld;
    mul_src_t mul_src;
    logic     p_ld;
    rnd_src_t rnd_src;
    logic     div_init;
    logic     div_step;
    logic     z_ld;
    logic     est_ld;
    logic     k_ld;
    logic     cov_ld;
    logic     out_ld;
  } ctrl_t;

  // One microcode word: controls plus sequencing
  typedef struct packed {
    ctrl_t ctrl;
    logic  cnt_ld;
    cond_t cond;
    step_t target;
    logic  ret;
  } uword_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gyro_gain;
    logic [PERIOD_W-1:0] sample_period;
    logic [PNOISE_W-1:0] process_noise;
    logic [RNOISE_W-1:0] measurement_noise;
  } cfg_t;

  // Clip a wide signed value to the estimate range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] c;
    if (v > ACC_MAX) begin
      c = ACC_MAX;
    end else if (v < ACC_MIN) begin
      c = ACC_MIN;
    end else begin
      c = v;
    end
    return c[ACC_W-1:0];
  endfunction

  // Microprogram of one filter step
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      STEP_IDLE: begin
        w.ctrl.in_ld   = 1'b1;
        w.ctrl.mul_src = MUL_GAIN_PERIOD;
        w.cond         = COND_NO_INPUT;
        w.target       = STEP_IDLE;
      end
      STEP_RATE: begin
        w.ctrl.mul_src = MUL_RATE;
        w.ctrl.p_ld    = 1'b1;
      end
      STEP_PRED_RND: begin
        w.ctrl.rnd_src  = RND_PRED;
        w.ctrl.div_init = 1'b1;
        w.ctrl.z_ld     = 1'b1;
        w.cnt_ld        = 1'b1;
      end
      STEP_PRED_ADD: begin
        w.ctrl.est_ld = 1'b1;
      end
      STEP_DIV: begin
        w.ctrl.div_step = 1'b1;
        w.cond          = COND_LOOP;
        w.target        = STEP_DIV;
      end
      STEP_GAIN: begin
        w.ctrl.k_ld = 1'b1;
      end
      STEP_CORR_MUL: begin
        w.ctrl.mul_src = MUL_DIFF_K;
      end
      STEP_CORR_RND: begin
        w.ctrl.rnd_src = RND_GAIN;
      end
      STEP_CORR_ADD: begin
        w.ctrl.est_ld  = 1'b1;
        w.ctrl.mul_src = MUL_COV_KC;
      end
      STEP_COV_RND: begin
        w.ctrl.rnd_src = RND_GAIN;
      end
      STEP_OUT: begin
        w.ctrl.cov_ld = 1'b1;
        w.ctrl.out_ld = 1'b1;
        w.cond        = COND_OUT_BUSY;
        w.target      = STEP_OUT;
        w.ret         = 1'b1;
      end
      default: begin
        w.ret = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/skaf_datapath.sv
// Arithmetic datapath of the angle fusion unit, driven by microcode controls
module skaf_datapath import skaf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctrl_t                          ctrl,
  input  cfg_t                           cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] in_angle_meas,
  input  logic signed [SAMPLE_WIDTH-1:0] in_gyro_rate,
  output logic signed [SAMPLE_WIDTH-1:0] out_fused_angle,
  output logic                           out_saturated
);

  localparam int S_PRED = IO_FRAC + GAIN_FRAC + PERIOD_FRAC - FRAC_BITS;
  localparam int S_OUT  = FRAC_BITS - IO_FRAC;

  localparam logic signed [WIDE-1:0] HALF_PRED = (WIDE'(1) << S_PRED) >> 1;
  localparam logic signed [WIDE-1:0] HALF_GAIN = (WIDE'(1) << K_BITS) >> 1;
  localparam logic signed [WIDE-1:0] HALF_OUT  = (WIDE'(1) << S_OUT) >> 1;
  localparam logic signed [WIDE-1:0] OUT_HI    = (WIDE'(1) << (SAMPLE_WIDTH - 1)) - WIDE'(1);
  localparam logic signed [WIDE-1:0] OUT_LO    = ~OUT_HI;
  localparam logic [K_BITS:0]        K_ONE     = {1'b1, {K_BITS{1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] meas_r, rate_r;
  logic signed [PROD_W-1:0]       mul_r, mul_nxt;
  logic signed [PROD_W-1:0]       rnd_r, rnd_nxt;
  logic signed [MUL_W-1:0]        mul_a, mul_b;
  logic signed [ACC_W-1:0]        est_r, est_nxt;
  logic signed [ACC_W-1:0]        z_r, z_nxt;
  logic signed [MUL_W-1:0]        diff_r, diff_nxt;
  logic [COV_W-1:0]               cov_r, p_r, p_nxt;
  logic [COV_W:0]                 p_sum;
  logic [COV_W:0]                 rem_r, rem_nxt, den_r, den_nxt;
  logic [COV_W+1:0]               rem_sh, rem_sub;
  logic                           q_bit;
  logic [K_BITS-1:0]              q_r;
  logic [K_BITS:0]                k_r, k_nxt;
  logic signed [WIDE-1:0]         rnd_sum, out_sum, out_val, out_clip;
  logic                           out_sat;

  // Select multiplier operands
  always_comb begin
    case (ctrl.mul_src)
      MUL_GAIN_PERIOD: begin
        mul_a = $signed({{(MUL_W - GAIN_W){1'b0}}, cfg.gyro_gain});
        mul_b = $signed({{(MUL_W - PERIOD_W){1'b0}}, cfg.sample_period});
      end
      MUL_RATE: begin
        mul_a = MUL_W'(rate_r);
        mul_b = $signed({{(MUL_W - GP_W){1'b0}}, mul_r[GP_W-1:0]});
      end
      MUL_DIFF_K: begin
        mul_a = diff_r;
        mul_b = $signed({{(MUL_W - K_BITS - 1){1'b0}}, k_r});
      end
      MUL_COV_KC: begin
        mul_a = $signed({{(MUL_W - COV_W){1'b0}}, p_r});
        mul_b = $signed({{(MUL_W - K_BITS - 1){1'b0}}, K_ONE - k_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_nxt = mul_a * mul_b;
  end

  // Round the product to nearest, ties upward
  always_comb begin
    case (ctrl.rnd_src)
      RND_PRED: begin
        rnd_sum = WIDE'(mul_r) + HALF_PRED;
        rnd_nxt = PROD_W'(rnd_sum >>> S_PRED);
      end
      RND_GAIN: begin
        rnd_sum = WIDE'(mul_r) + HALF_GAIN;
        rnd_nxt = PROD_W'(rnd_sum >>> K_BITS);
      end
      default: begin
        rnd_sum = '0;
        rnd_nxt = rnd_r;
      end
    endcase
  end

  // Estimate, measurement and covariance arithmetic
  always_comb begin
    est_nxt  = sat_acc(WIDE'(est_r) + WIDE'(rnd_r));
    z_nxt    = sat_acc(WIDE'(meas_r) <<< S_OUT);
    diff_nxt = MUL_W'(z_r) - MUL_W'(est_r);
    p_sum    = {1'b0, cov_r} + (COV_W + 1)'(cfg.process_noise);
    p_nxt    = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
    den_nxt  = {1'b0, p_r} + (COV_W + 1)'(cfg.measurement_noise);
  end

  // One restoring division step for the gain
  always_comb begin
    rem_sh  = {rem_r, 1'b0};
    rem_sub = rem_sh - {1'b0, den_r};
    q_bit   = rem_sh >= {1'b0, den_r};
    rem_nxt = q_bit ? rem_sub[COV_W:0] : rem_sh[COV_W:0];
  end

  // Pick the gain: exactly one with no measurement noise, zero on a zero denominator
  always_comb begin
    if (cfg.measurement_noise == '0) begin
      k_nxt = (p_r == '0) ? '0 : K_ONE;
    end else begin
      k_nxt = {1'b0, q_r};
    end
  end

  // Round and clip the estimate for the result
  always_comb begin
    out_sum = WIDE'(est_r) + HALF_OUT;
    out_val = out_sum >>> S_OUT;
    if (out_val > OUT_HI) begin
      out_clip = OUT_HI;
      out_sat  = 1'b1;
    end else if (out_val < OUT_LO) begin
      out_clip = OUT_LO;
      out_sat  = 1'b1;
    end else begin
      out_clip = out_val;
      out_sat  = 1'b0;
    end
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      cov_r <= COV_RST;
    end else begin
      if (ctrl.est_ld) begin
        est_r <= est_nxt;
      end
      if (ctrl.cov_ld) begin
        cov_r <= rnd_r[COV_W-1:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.in_ld) begin
      meas_r <= in_angle_meas;
      rate_r <= in_gyro_rate;
    end
    if (ctrl.mul_src != MUL_NONE) begin
      mul_r <= mul_nxt;
    end
    rnd_r <= rnd_nxt;
    if (ctrl.p_ld) begin
      p_r <= p_nxt;
    end
    if (ctrl.z_ld) begin
      z_r <= z_nxt;
    end
    if (ctrl.div_init) begin
      rem_r <= {1'b0, p_r};
      den_r <= den_nxt;
      q_r   <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[K_BITS-2:0], q_bit};
    end
    if (ctrl.k_ld) begin
      k_r    <= k_nxt;
      diff_r <= diff_nxt;
    end
    if (ctrl.out_ld) begin
      out_fused_angle <= out_clip[SAMPLE_WIDTH-1:0];
      out_saturated   <= out_sat;
    end
  end

endmodule

FILE: rtl/scalar_kalman_angle_fusion_unit.sv
// Scalar Kalman filter fusing an accelerometer angle with a gyro rate.
// Input channel: in_valid / in_stall with in_angle_meas and in_gyro_rate,
// both signed with 8 fraction bits. A transfer happens on a clock edge with
// in_valid high and in_stall low. Result channel: out_valid / out_stall with
// out_fused_angle (same format, clipped) and out_saturated.
// Configuration: cfg_we writes cfg_wdata into the register chosen by
// cfg_index (gain, sample period, process noise, measurement noise); write
// only while the unit is idle.
// Sequencing: a microcoded sequencer walks one step program per item. The
// result is registered in the output step, and a new item is taken only once
// the program is back in the idle step; the restoring division of the gain
// takes most of the program, with one shared 33 by 33 multiplier for the rest.
// in_stall is low only in the idle step and out of reset. The result sits in
// an output register, so the next item may be taken while it waits; if the
// receiver still stalls when the following result is ready, the final step
// holds.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// estimate, sets the covariance to 300.0 and drops any pending result.
`include "scalar_kalman_angle_fusion_unit_assert.svh"

module scalar_kalman_angle_fusion_unit import skaf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_angle_meas,
  input  logic signed [SAMPLE_WIDTH-1:0] in_gyro_rate,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_fused_angle,
  output logic                           out_saturated
);

  step_t            pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  cfg_t             cfg_r, cfg_nxt;
  uword_t           uw;
  ctrl_t            ctrl;
  logic             in_xfer, out_busy, jump;

  // Fetch the control word of the current step; refuse input during reset
  always_comb begin
    uw       = ucode(pc_r);
    in_stall = !rst_n || (pc_r != STEP_IDLE);
    in_xfer  = in_valid && !in_stall;
    out_busy = out_valid_r && out_stall;
    ctrl        = uw.ctrl;
    ctrl.in_ld  = uw.ctrl.in_ld && in_xfer;
    ctrl.out_ld = uw.ctrl.out_ld && !out_busy;
  end

  // Evaluate the jump condition and advance the step counter
  always_comb begin
    unique case (uw.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_INPUT: jump = !in_valid;
      COND_LOOP:     jump = (cnt_r != CNT_W'(1));
      COND_OUT_BUSY: jump = out_busy;
    endcase
    if (jump) begin
      pc_nxt = uw.target;
    end else if (uw.ret) begin
      pc_nxt = STEP_IDLE;
    end else begin
      pc_nxt = step_t'(pc_r + 1'b1);
    end
    if (uw.cnt_ld) begin
      cnt_nxt = CNT_W'(K_BITS);
    end else if (uw.ctrl.div_step) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Hold the result until its transfer
  always_comb begin
    if (ctrl.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GYRO_GAIN:         cfg_nxt.gyro_gain         = cfg_wdata[GAIN_W-1:0];
        CFG_SAMPLE_PERIOD:     cfg_nxt.sample_period     = cfg_wdata[PERIOD_W-1:0];
        CFG_PROCESS_NOISE:     cfg_nxt.process_noise     = cfg_wdata[PNOISE_W-1:0];
        CFG_MEASUREMENT_NOISE: cfg_nxt.measurement_noise = cfg_wdata[RNOISE_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r                    <= STEP_IDLE;
      cnt_r                   <= '0;
      out_valid_r             <= 1'b0;
      cfg_r.gyro_gain         <= GYRO_GAIN_RST;
      cfg_r.sample_period     <= PERIOD_RST;
      cfg_r.process_noise     <= PNOISE_RST;
      cfg_r.measurement_noise <= RNOISE_RST;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  assign out_valid = out_valid_r;

  skaf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .cfg             (cfg_r),
    .in_angle_meas   (in_angle_meas),
    .in_gyro_rate    (in_gyro_rate),
    .out_fused_angle (out_fused_angle),
    .out_saturated   (out_saturated)
  );

  // Checks on the sequencer
  `SKAF_ASSERT_NEXT(a_xfer_starts_step, in_valid && !in_stall, pc_r == STEP_RATE, "input transfer did not start the step program")
  `SKAF_ASSERT_IMPLIES(a_div_count_live, pc_r == STEP_DIV, cnt_r != '0, "division loop entered with an empty count")
  `SKAF_ASSERT_IMPLIES(a_result_from_out_step, $rose(out_valid_r), $past(pc_r) == STEP_OUT, "result raised outside the output step")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the scalar Kalman angle fusion unit
`timescale 1ns / 1ps

module testbench;
  import skaf_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 135;
  localparam int MAX_PRINTED = 40;

  // Fixed-point helpers of the filter arithmetic
  localparam int DRIFT_SHIFT = IO_FRAC + GAIN_FRAC + PERIOD_FRAC - FRAC_BITS_DEF;
  localparam int OUT_SHIFT = FRAC_BITS_DEF - IO_FRAC;
  localparam longint K_ONE = longint'(1) <<< K_BITS;
  localparam longint K_HALF = longint'(1) <<< (K_BITS - 1);
  localparam longint COV_CEIL = 64'h0000_0000_FFFF_FFFF;
  localparam longint ACC_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint OUT_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;
  localparam logic signed [SW-1:0] SAMPLE_MAX = OUT_HI[SW-1:0];
  localparam logic signed [SW-1:0] SAMPLE_MIN = OUT_LO[SW-1:0];

  typedef struct packed {
    logic signed [SW-1:0] fused;
    logic                 sat;
  } fusion_out_t;

  typedef struct packed {
    logic        pinned;
    fusion_out_t value;
  } pin_t;

  typedef enum logic [1:0] {ROW_SETTINGS, ROW_PREDICT, ROW_PINNED} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [GAIN_W-1:0]    gain;
    logic [PERIOD_W-1:0]  period;
    logic [PNOISE_W-1:0]  pnoise;
    logic [RNOISE_W-1:0]  rnoise;
    logic signed [SW-1:0] angle;
    logic signed [SW-1:0] rate;
    logic signed [SW-1:0] fused;
    logic                 sat;
  } plan_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HOLD, STALL_RARE} stall_mode_t;

  // Directed sequence: settings changes and samples, pinned results where obvious
  localparam int PLAN_ROWS = 22;
  plan_row_t plan [PLAN_ROWS] = '{
    // reset state, zero input keeps the estimate at zero
    '{ROW_PINNED, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sh8000, 16'sd0, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd0, 16'sh7FFF, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd0, 16'sh8000, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sh5555, 16'shAAAA, 16'sd0, 1'b0},
    // zero measurement noise: the estimate takes the measurement exactly
    '{ROW_SETTINGS, 16'd1152, 16'd1049, 24'd3277, 32'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{ROW_PINNED, 16'd0, 16'd0, 24'd0, 32'd0, 16'sh7FFF, 16'sd1234, 16'sh7FFF, 1'b0},
    '{ROW_PINNED, 16'd0, 16'd0, 24'd0, 32'd0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0},
    '{ROW_PINNED, 16'd0, 16'd0, 24'd0, 32'd0, 16'sh1234, -16'sd7, 16'sh1234, 1'b0},
    // covariance now zero, no process noise: zero denominator gives zero gain
    '{ROW_SETTINGS, 16'd1152, 16'd1049, 24'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd1000, 16'sd500, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, -16'sd2000, 16'sh7FFF, 16'sd0, 1'b0},
    // zero sample period: prediction leaves the estimate alone
    '{ROW_SETTINGS, 16'd1152, 16'd0, 24'd3277, 32'd65536000, 16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd300, 16'sh7FFF, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, -16'sd300, 16'sh8000, 16'sd0, 1'b0},
    // largest gain, period and noise: estimate overflow and output clipping
    '{ROW_SETTINGS, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
      16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{ROW_PINNED, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 1'b1},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd0, 16'sh8000, 16'sd0, 1'b0},
    '{ROW_PINNED, 16'd0, 16'd0, 24'd0, 32'd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b1},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 16'sd0, 1'b0},
    '{ROW_PREDICT, 16'd0, 16'd0, 24'd0, 32'd0, -16'sd1, 16'sd1, 16'sd0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GYRO_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [SW-1:0]  in_angle_meas = '0;
  logic signed [SW-1:0]  in_gyro_rate = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [SW-1:0]  out_fused_angle;
  logic                  out_saturated;

  // Filter state and settings mirrored by the predictor
  cfg_t   filt_cfg = '{GYRO_GAIN_RST, PERIOD_RST, PNOISE_RST, RNOISE_RST};
  longint est_acc = 0;
  longint cov_acc = COV_RST;

  fusion_out_t pending_fusions[$];
  pin_t        pinned_values[$];

  int          samples_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          stall_run = 0;
  stall_mode_t stall_mode = STALL_NONE;

  scalar_kalman_angle_fusion_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_angle_meas   (in_angle_meas),
    .in_gyro_rate    (in_gyro_rate),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fused_angle (out_fused_angle),
    .out_saturated   (out_saturated)
  );

  always #5 clk = ~clk;

  function automatic longint clip_acc(input longint v);
    if (v > ACC_HI) begin
      return ACC_HI;
    end
    if (v < ACC_LO) begin
      return ACC_LO;
    end
    return v;
  endfunction

  // One filter step: predict, correct, then round and clip the estimate
  function automatic fusion_out_t advance_filter(input logic signed [SW-1:0] angle,
                                                 input logic signed [SW-1:0] rate);
    longint drift, gain, period, p, denom, k, meas, diff, outv;
    fusion_out_t r;
    gain = filt_cfg.gyro_gain;
    period = filt_cfg.sample_period;
    drift = longint'(rate) * gain * period;
    drift = (drift + (longint'(1) <<< (DRIFT_SHIFT - 1))) >>> DRIFT_SHIFT;
    est_acc = clip_acc(est_acc + drift);

    p = filt_cfg.process_noise;
    p = p + cov_acc;
    if (p > COV_CEIL) begin
      p = COV_CEIL;
    end
    denom = filt_cfg.measurement_noise;
    denom = denom + p;
    k = (denom == 0) ? 0 : (p <<< K_BITS) / denom;

    meas = angle;
    diff = clip_acc(meas <<< OUT_SHIFT) - est_acc;
    est_acc = clip_acc(est_acc + ((diff * k + K_HALF) >>> K_BITS));
    cov_acc = ((p * (K_ONE - k) + K_HALF) >>> K_BITS) & COV_CEIL;

    outv = (est_acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    r.sat = 1'b0;
    if (outv > OUT_HI) begin
      outv = OUT_HI;
      r.sat = 1'b1;
    end
    if (outv < OUT_LO) begin
      outv = OUT_LO;
      r.sat = 1'b1;
    end
    r.fused = outv[SW-1:0];
    return r;
  endfunction

  // Random register value: half the time spread over magnitudes, else an extreme or the default
  function automatic logic [CFG_DATA_W-1:0] pick_level(input logic [CFG_DATA_W-1:0] lo,
                                                      input logic [CFG_DATA_W-1:0] hi,
                                                      input logic [CFG_DATA_W-1:0] dflt);
    logic [CFG_DATA_W-1:0] v;
    v = ($urandom & hi) >> $urandom_range(0, 24);
    if (v < lo) begin
      v = lo;
    end
    case ($urandom_range(0, 5))
      0: v = lo;
      1: v = hi;
      2: v = dflt;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] v;
    v = SW'($urandom);
    case ($urandom_range(0, 5))
      0: v = v >>> 6;
      1: v = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] result %0d: %s got %0d, expected %0d",
               $time, results_seen, what, got, want);
    end
  endtask

  // Hold the sender until every outstanding result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (results_seen < samples_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic change_settings(input cfg_t c);
    wait_for_results();
    write_reg(CFG_GYRO_GAIN, CFG_DATA_W'(c.gyro_gain));
    write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'(c.sample_period));
    write_reg(CFG_PROCESS_NOISE, CFG_DATA_W'(c.process_noise));
    write_reg(CFG_MEASUREMENT_NOISE, CFG_DATA_W'(c.measurement_noise));
    cfg_we <= 1'b0;
    filt_cfg = c;
  endtask

  // Offer one sample, wait for its transfer, then maybe end the burst
  task automatic send_sample(input logic signed [SW-1:0] angle,
                             input logic signed [SW-1:0] rate,
                             input logic pinned,
                             input logic signed [SW-1:0] fused,
                             input logic sat);
    pin_t pin;
    int gap;
    pin.pinned = pinned;
    pin.value.fused = fused;
    pin.value.sat = sat;
    pinned_values.push_back(pin);
    in_angle_meas <= angle;
    in_gyro_rate <= rate;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver stall pattern: runs of no stall, coin flips, solid holds, rare stalls
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_run <= $urandom_range(1, 120);
      out_stall <= 1'b0;
    end else begin
      stall_run <= stall_run - 1;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
        STALL_HOLD: out_stall <= 1'b1;
        default:    out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Predict the result of each input transfer
  always @(posedge clk) begin : accept_samples
    fusion_out_t predicted;
    pin_t pin;
    if (rst_n && in_valid && !in_stall) begin
      predicted = advance_filter(in_angle_meas, in_gyro_rate);
      pin = pinned_values.pop_front();
      pending_fusions.push_back(pin.pinned ? pin.value : predicted);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    fusion_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_fusions.size() == 0) begin
        report_mismatch("result with nothing expected, fused_angle", out_fused_angle, 0);
      end else begin
        want = pending_fusions.pop_front();
        if (out_fused_angle !== want.fused) begin
          report_mismatch("fused_angle", out_fused_angle, $signed(want.fused));
        end
        if (out_saturated !== want.sat) begin
          report_mismatch("saturated", out_saturated, want.sat);
        end
      end
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("[%0t] no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETTINGS) begin
        c.gyro_gain = plan[i].gain;
        c.sample_period = plan[i].period;
        c.process_noise = plan[i].pnoise;
        c.measurement_noise = plan[i].rnoise;
        change_settings(c);
      end else begin
        send_sample(plan[i].angle, plan[i].rate, plan[i].kind == ROW_PINNED,
                    plan[i].fused, plan[i].sat);
      end
    end

    // Random phases, defaults first, then random settings with extremes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        c = '{GYRO_GAIN_RST, PERIOD_RST, PNOISE_RST, RNOISE_RST};
      end else begin
        c.gyro_gain = GAIN_W'(pick_level(32'd0, 32'h0000_FFFF, 32'(GYRO_GAIN_RST)));
        c.sample_period = PERIOD_W'(pick_level(32'd1, 32'h0000_FFFF, 32'(PERIOD_RST)));
        c.process_noise = PNOISE_W'(pick_level(32'd0, 32'h00FF_FFFF, 32'(PNOISE_RST)));
        c.measurement_noise = pick_level(32'd1, 32'hFFFF_FFFF, RNOISE_RST);
      end
      change_settings(c);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 59) == 0) begin
          wait_for_results();
        end
        send_sample(pick_sample(), pick_sample(), 1'b0, '0, 1'b0);
      end
    end

    // Drain, then give stray results time to show
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_fusions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
